// ----- design/dssl_pkg.sv -----
// ----------------------------------------------------------------------------
// dssl_pkg: shared types and constants of the serial status link unit
// Frame geometry, field widths, opcode and register codes, and the classified
// request that travels from the front end through the queue to the back end.
// ----------------------------------------------------------------------------
`default_nettype none

package dssl_pkg;

  // Frame geometry
  localparam int FrameBytes = 13;
  localparam int StatBytes  = FrameBytes - 2;
  localparam int TotalBits  = FrameBytes * 8;
  localparam int ByteIdxW   = $clog2(FrameBytes);
  localparam int BitPosW    = $clog2(TotalBits);
  localparam int StatAddrW  = (StatBytes > 1) ? $clog2(StatBytes) : 1;

  // Port field widths
  localparam int OpcodeW   = 2;
  localparam int StatIdxW  = 4;
  localparam int ByteW     = 8;
  localparam int StateW    = 3;
  localparam int WaitW     = 24;
  localparam int CmdIdxW   = 4;
  localparam int CfgIdxW   = 3;

  // Request queue
  localparam int QueueDepth = 2;
  localparam int QPtrW      = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
  localparam int QCntW      = $clog2(QueueDepth + 1);

  // Opcodes
  localparam logic [OpcodeW-1:0] OpTick = 2'd0;
  localparam logic [OpcodeW-1:0] OpBit  = 2'd1;
  localparam logic [OpcodeW-1:0] OpLoad = 2'd2;

  // Register indexes
  localparam logic [CfgIdxW-1:0] CfgPowerOnWait = 3'd0;
  localparam logic [CfgIdxW-1:0] CfgBeginWait   = 3'd1;
  localparam logic [CfgIdxW-1:0] CfgInterWait   = 3'd2;
  localparam logic [CfgIdxW-1:0] CfgByteWait    = 3'd3;
  localparam logic [CfgIdxW-1:0] CfgEndWait     = 3'd4;

  // Register reset values
  localparam logic [WaitW-1:0] PowerOnWaitRst = 24'd100000;
  localparam logic [WaitW-1:0] BeginWaitRst   = 24'd1000;
  localparam logic [WaitW-1:0] InterWaitRst   = 24'd500;
  localparam logic [WaitW-1:0] ByteWaitRst    = 24'd2000;
  localparam logic [WaitW-1:0] EndWaitRst     = 24'd1;

  // Request class decided by the front end
  typedef enum logic [1:0] {
    KindTick,
    KindBit,
    KindLoad,
    KindNop
  } kind_e;

  typedef struct packed {
    kind_e               kind;
    logic                bit_in;
    logic [ByteIdxW-1:0] sidx;
    logic [ByteW-1:0]    sval;
  } item_t;

endpackage

`default_nettype wire

// ----- design/drive_serial_status_link_unit.sv -----
// ----------------------------------------------------------------------------
// drive_serial_status_link_unit: drive side of a serial command/status link
// Front end, request queue and link sequencer for 13-byte frames.
// ----------------------------------------------------------------------------
// The unit takes one request per clock cycle while the request queue has room
// and returns one result per cycle while the result channel is ready; a tick,
// bit exchange, status load or unused opcode yields one result, via the queue
// and output register, while the end tick yields thirteen, one per command byte.
// The single output register sets the sustained rate: one result per cycle
// while results are taken; the two-entry queue absorbs intake during end ticks.
// Timing registers are written through the configuration channel, which is
// always ready; write them only while no request is in flight.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_serial_status_link_unit (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           cfg_valid_i,
  output logic                                cfg_ready_o,
  input  wire logic [dssl_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  wire logic [dssl_pkg::WaitW-1:0]     cfg_data_i,
  input  wire logic                           in_valid_i,
  output logic                                in_ready_o,
  input  wire logic [dssl_pkg::OpcodeW-1:0]   opcode_i,
  input  wire logic                           bit_in_i,
  input  wire logic [dssl_pkg::StatIdxW-1:0]  status_index_i,
  input  wire logic [dssl_pkg::ByteW-1:0]     status_value_i,
  output logic                                out_valid_o,
  input  wire logic                           out_ready_i,
  output logic                                status_bit_o,
  output logic                                req_line_n_o,
  output logic                                sync_line_n_o,
  output logic [dssl_pkg::StateW-1:0]         link_state_o,
  output logic [dssl_pkg::WaitW-1:0]          wait_cycles_o,
  output logic                                cmd_valid_o,
  output logic [dssl_pkg::CmdIdxW-1:0]        cmd_index_o,
  output logic [dssl_pkg::ByteW-1:0]          cmd_byte_o,
  output logic                                last_o
);
  import dssl_pkg::*;

  logic  push_valid, push_ready, pop_valid, pop_ready;
  item_t push_item, pop_item;

  assign cfg_ready_o = 1'b1;

  // Classify incoming requests
  dssl_front u_front (
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .bit_in_i       (bit_in_i),
    .status_index_i (status_index_i),
    .status_value_i (status_value_i),
    .push_valid_o   (push_valid),
    .push_ready_i   (push_ready),
    .push_item_o    (push_item)
  );

  // Buffer classified requests
  dssl_queue u_queue (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_valid_i (push_valid),
    .push_ready_o (push_ready),
    .push_item_i  (push_item),
    .pop_valid_o  (pop_valid),
    .pop_ready_i  (pop_ready),
    .pop_item_o   (pop_item)
  );

  // Execute requests and register results
  dssl_back u_back (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .cfg_valid_i   (cfg_valid_i),
    .cfg_index_i   (cfg_index_i),
    .cfg_data_i    (cfg_data_i),
    .item_valid_i  (pop_valid),
    .item_ready_o  (pop_ready),
    .item_i        (pop_item),
    .out_valid_o   (out_valid_o),
    .out_ready_i   (out_ready_i),
    .status_bit_o  (status_bit_o),
    .req_line_n_o  (req_line_n_o),
    .sync_line_n_o (sync_line_n_o),
    .link_state_o  (link_state_o),
    .wait_cycles_o (wait_cycles_o),
    .cmd_valid_o   (cmd_valid_o),
    .cmd_index_o   (cmd_index_o),
    .cmd_byte_o    (cmd_byte_o),
    .last_o        (last_o)
  );

endmodule

`default_nettype wire

// ----- design/dssl_front.sv -----
// ----------------------------------------------------------------------------
// dssl_front: request intake and classification
// Takes requests from the input channel, sorts them into tick, bit exchange,
// status load or no-op, and hands them to the request queue.
// ----------------------------------------------------------------------------
`default_nettype none

module dssl_front (
  input  wire logic                            in_valid_i,
  output logic                                 in_ready_o,
  input  wire logic [dssl_pkg::OpcodeW-1:0]    opcode_i,
  input  wire logic                            bit_in_i,
  input  wire logic [dssl_pkg::StatIdxW-1:0]   status_index_i,
  input  wire logic [dssl_pkg::ByteW-1:0]      status_value_i,
  output logic                                 push_valid_o,
  input  wire logic                            push_ready_i,
  output dssl_pkg::item_t                      push_item_o
);
  import dssl_pkg::*;

  logic load_ok;

  // Pass the handshake straight to the queue
  assign in_ready_o   = push_ready_i;
  assign push_valid_o = in_valid_i;

  // Drop loads aimed at the checksum byte or beyond
  assign load_ok = int'(status_index_i) < StatBytes;

  // Classify the request
  always_comb begin
    push_item_o.bit_in = bit_in_i;
    push_item_o.sidx   = ByteIdxW'(status_index_i);
    push_item_o.sval   = status_value_i;
    case (opcode_i)
      OpTick:  push_item_o.kind = KindTick;
      OpBit:   push_item_o.kind = KindBit;
      OpLoad:  push_item_o.kind = load_ok ? KindLoad : KindNop;
      default: push_item_o.kind = KindNop;
    endcase
  end

endmodule

`default_nettype wire

// ----- design/dssl_queue.sv -----
// ----------------------------------------------------------------------------
// dssl_queue: short request queue between front end and back end
// Holds classified requests so that intake and execution stall independently.
// ----------------------------------------------------------------------------
`default_nettype none

module dssl_queue (
  input  wire logic            clk_i,
  input  wire logic            rst_ni,
  input  wire logic            push_valid_i,
  output logic                 push_ready_o,
  input  wire dssl_pkg::item_t push_item_i,
  output logic                 pop_valid_o,
  input  wire logic            pop_ready_i,
  output dssl_pkg::item_t      pop_item_o
);
  import dssl_pkg::*;

  item_t             mem_q [QueueDepth];
  logic [QPtrW-1:0]  wr_ptr_q, wr_ptr_d;
  logic [QPtrW-1:0]  rd_ptr_q, rd_ptr_d;
  logic [QCntW-1:0]  count_q, count_d;
  logic              push, pop;

  assign push_ready_o = count_q != QCntW'(QueueDepth);
  assign pop_valid_o  = count_q != '0;
  assign pop_item_o   = mem_q[rd_ptr_q];
  assign push         = push_valid_i && push_ready_o;
  assign pop          = pop_valid_o && pop_ready_i;

  // Advance pointers and fill count
  always_comb begin
    wr_ptr_d = wr_ptr_q;
    rd_ptr_d = rd_ptr_q;
    count_d  = count_q;
    if (push) begin
      wr_ptr_d = (wr_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : wr_ptr_q + 1'b1;
    end
    if (pop) begin
      rd_ptr_d = (rd_ptr_q == QPtrW'(QueueDepth - 1)) ? '0 : rd_ptr_q + 1'b1;
    end
    if (push && !pop) begin
      count_d = count_q + 1'b1;
    end else if (pop && !push) begin
      count_d = count_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      wr_ptr_q <= wr_ptr_d;
      rd_ptr_q <= rd_ptr_d;
      count_q  <= count_d;
    end
  end

  // Store the incoming request
  always_ff @(posedge clk_i) begin
    if (push) begin
      mem_q[wr_ptr_q] <= push_item_i;
    end
  end

endmodule

`default_nettype wire

// ----- design/dssl_back.sv -----
// ----------------------------------------------------------------------------
// dssl_back: link sequencer and result stage
// Executes queued requests against the link state, command and status stores,
// and registers one result per cycle while the result channel is ready; an end
// tick expands into one result per command byte.
// ----------------------------------------------------------------------------
`default_nettype none

module dssl_back (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_valid_i,
  input  wire logic [dssl_pkg::CfgIdxW-1:0]     cfg_index_i,
  input  wire logic [dssl_pkg::WaitW-1:0]       cfg_data_i,
  input  wire logic                             item_valid_i,
  output logic                                  item_ready_o,
  input  wire dssl_pkg::item_t                  item_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_ready_i,
  output logic                                  status_bit_o,
  output logic                                  req_line_n_o,
  output logic                                  sync_line_n_o,
  output logic [dssl_pkg::StateW-1:0]           link_state_o,
  output logic [dssl_pkg::WaitW-1:0]            wait_cycles_o,
  output logic                                  cmd_valid_o,
  output logic [dssl_pkg::CmdIdxW-1:0]          cmd_index_o,
  output logic [dssl_pkg::ByteW-1:0]            cmd_byte_o,
  output logic                                  last_o
);
  import dssl_pkg::*;

  typedef enum logic [StateW-1:0] {
    PhReset  = 3'd0,
    PhPre    = 3'd1,
    PhBegin  = 3'd2,
    PhByte   = 3'd3,
    PhInter1 = 3'd4,
    PhInterN = 3'd5,
    PhEnd    = 3'd6
  } phase_e;

  // Timing registers
  logic [WaitW-1:0] power_on_wait_q, begin_wait_q, inter_wait_q, byte_wait_q, end_wait_q;

  // Link state
  phase_e              phase_q, phase_d;
  logic                req_q, req_d;
  logic                sync_q, sync_d;
  logic [BitPosW-1:0]  cp_q, cp_d;
  logic [BitPosW-1:0]  sp_q, sp_d;
  logic [ByteW-1:0]    sum_q, sum_d;
  logic                csum_set_q, csum_set_d;
  logic [ByteIdxW-1:0] k_q, k_d;
  logic [ByteW-1:0]    cmd_q  [FrameBytes];
  logic [ByteW-1:0]    stat_q [StatBytes];

  // Result register
  logic                out_valid_q;
  logic                out_sbit_q, out_req_q, out_sync_q, out_cvalid_q, out_last_q;
  logic [StateW-1:0]   out_state_q;
  logic [WaitW-1:0]    out_wait_q;
  logic [CmdIdxW-1:0]  out_cidx_q;
  logic [ByteW-1:0]    out_cbyte_q;

  // Execution signals
  logic                fire, pop, cmd_we, stat_we, k_last;
  logic [BitPosW:0]    cp_inc;
  logic [ByteIdxW-1:0] rd_addr;
  logic [ByteW-1:0]    rd_byte, csum;
  logic                res_sbit, res_cvalid;
  logic [StateW-1:0]   res_state;
  logic [WaitW-1:0]    res_wait;
  logic [CmdIdxW-1:0]  res_cidx;
  logic [ByteW-1:0]    res_cbyte;

  // Write timing registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      power_on_wait_q <= PowerOnWaitRst;
      begin_wait_q    <= BeginWaitRst;
      inter_wait_q    <= InterWaitRst;
      byte_wait_q     <= ByteWaitRst;
      end_wait_q      <= EndWaitRst;
    end else if (cfg_valid_i) begin
      case (cfg_index_i)
        CfgPowerOnWait: power_on_wait_q <= cfg_data_i;
        CfgBeginWait:   begin_wait_q    <= cfg_data_i;
        CfgInterWait:   inter_wait_q    <= cfg_data_i;
        CfgByteWait:    byte_wait_q     <= cfg_data_i;
        CfgEndWait:     end_wait_q      <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Read one status byte: a load needs the old value, a bit exchange its byte
  assign csum    = csum_set_q ? ~sum_q : '0;
  assign rd_addr = (item_i.kind == KindLoad) ? item_i.sidx : sp_q[BitPosW-1:3];

  always_comb begin
    if (rd_addr < ByteIdxW'(StatBytes)) begin
      rd_byte = stat_q[rd_addr[StatAddrW-1:0]];
    end else if (rd_addr == ByteIdxW'(StatBytes)) begin
      rd_byte = csum;
    end else begin
      rd_byte = '0;
    end
  end

  assign fire   = item_valid_i && (!out_valid_q || out_ready_i);
  assign k_last = k_q == ByteIdxW'(FrameBytes - 1);
  assign cp_inc = {1'b0, cp_q} + 1'b1;

  // Execute the request at the queue head
  always_comb begin
    phase_d    = phase_q;
    req_d      = req_q;
    sync_d     = sync_q;
    cp_d       = cp_q;
    sp_d       = sp_q;
    sum_d      = sum_q;
    csum_set_d = csum_set_q;
    k_d        = k_q;
    cmd_we     = 1'b0;
    stat_we    = 1'b0;
    pop        = fire;
    res_sbit   = 1'b0;
    res_wait   = '0;
    res_cvalid = 1'b0;
    res_cidx   = '0;
    res_cbyte  = '0;
    case (item_i.kind)
      KindTick: begin
        case (phase_q)
          PhReset: begin
            req_d    = 1'b1;
            sync_d   = 1'b1;
            phase_d  = PhPre;
            res_wait = power_on_wait_q;
          end
          PhPre: begin
            phase_d  = PhBegin;
            res_wait = begin_wait_q;
          end
          PhBegin: begin
            sync_d   = 1'b0;
            phase_d  = PhByte;
            res_wait = inter_wait_q;
          end
          PhByte: begin
            req_d    = 1'b0;
            res_wait = byte_wait_q;
          end
          PhInter1: begin
            req_d    = 1'b1;
            phase_d  = PhByte;
            res_wait = inter_wait_q;
          end
          PhInterN: begin
            phase_d  = PhByte;
            res_wait = inter_wait_q;
          end
          PhEnd: begin
            // A command byte per cycle unless stalled; leave PhEnd on the last
            res_wait   = end_wait_q;
            res_cvalid = 1'b1;
            res_cidx   = CmdIdxW'(k_q);
            res_cbyte  = cmd_q[k_q];
            if (k_last) begin
              phase_d = PhPre;
              k_d     = '0;
            end else begin
              k_d = k_q + 1'b1;
              pop = 1'b0;
            end
          end
          default: begin
            phase_d  = PhPre;
            res_wait = begin_wait_q;
          end
        endcase
      end
      KindBit: begin
        res_sbit = rd_byte[sp_q[2:0]];
        sp_d     = (sp_q == BitPosW'(TotalBits - 1)) ? '0 : sp_q + 1'b1;
        cmd_we   = 1'b1;
        cp_d     = cp_inc[BitPosW-1:0];
        if (cp_inc[2:0] == 3'd0) begin
          if (cp_inc == (BitPosW + 1)'(TotalBits)) begin
            cp_d    = '0;
            phase_d = PhEnd;
          end else if (cp_inc == (BitPosW + 1)'(8)) begin
            phase_d = PhInter1;
          end else begin
            phase_d = PhInterN;
          end
          req_d  = 1'b1;
          sync_d = 1'b1;
        end
      end
      KindLoad: begin
        stat_we    = 1'b1;
        sum_d      = sum_q - rd_byte + item_i.sval;
        csum_set_d = 1'b1;
      end
      default: ;
    endcase
    // Every end-tick result shows the phase the tick leaves behind
    res_state = (item_i.kind == KindTick && phase_q == PhEnd) ? PhPre : phase_d;
  end

  assign item_ready_o = pop;

  // Hold link state, stores and the result register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= PhReset;
      req_q       <= 1'b1;
      sync_q      <= 1'b1;
      cp_q        <= '0;
      sp_q        <= '0;
      sum_q       <= '0;
      csum_set_q  <= 1'b0;
      k_q         <= '0;
      cmd_q       <= '{default: '0};
      stat_q      <= '{default: '0};
      out_valid_q <= 1'b0;
    end else begin
      if (fire) begin
        phase_q    <= phase_d;
        req_q      <= req_d;
        sync_q     <= sync_d;
        cp_q       <= cp_d;
        sp_q       <= sp_d;
        sum_q      <= sum_d;
        csum_set_q <= csum_set_d;
        k_q        <= k_d;
        if (cmd_we) begin
          cmd_q[cp_q[BitPosW-1:3]][cp_q[2:0]] <= item_i.bit_in;
        end
        if (stat_we) begin
          stat_q[item_i.sidx[StatAddrW-1:0]] <= item_i.sval;
        end
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // Capture result fields
  always_ff @(posedge clk_i) begin
    if (fire) begin
      out_sbit_q   <= res_sbit;
      out_req_q    <= req_d;
      out_sync_q   <= sync_d;
      out_state_q  <= res_state;
      out_wait_q   <= res_wait;
      out_cvalid_q <= res_cvalid;
      out_cidx_q   <= res_cidx;
      out_cbyte_q  <= res_cbyte;
      out_last_q   <= !(res_cvalid && !k_last);
    end
  end

  assign out_valid_o   = out_valid_q;
  assign status_bit_o  = out_sbit_q;
  assign req_line_n_o  = out_req_q;
  assign sync_line_n_o = out_sync_q;
  assign link_state_o  = out_state_q;
  assign wait_cycles_o = out_wait_q;
  assign cmd_valid_o   = out_cvalid_q;
  assign cmd_index_o   = out_cidx_q;
  assign cmd_byte_o    = out_cbyte_q;
  assign last_o        = out_last_q;

endmodule

`default_nettype wire

// ----- design/dssl_checker.sv -----
// ----------------------------------------------------------------------------
// dssl_checker: port-level checks for the serial status link unit
// Watches the top-level ports and flags result sequences that break the link
// rules; bound to the top level below.
// ----------------------------------------------------------------------------
`default_nettype none

module dssl_checker (
  input  wire logic                           clk_i,
  input  wire logic                           rst_ni,
  input  wire logic                           out_valid_o,
  input  wire logic                           out_ready_i,
  input  wire logic                           status_bit_o,
  input  wire logic                           sync_line_n_o,
  input  wire logic [dssl_pkg::StateW-1:0]    link_state_o,
  input  wire logic [dssl_pkg::WaitW-1:0]     wait_cycles_o,
  input  wire logic                           cmd_valid_o,
  input  wire logic [dssl_pkg::CmdIdxW-1:0]   cmd_index_o,
  input  wire logic [dssl_pkg::ByteW-1:0]     cmd_byte_o,
  input  wire logic                           last_o
);
  import dssl_pkg::*;

  localparam logic [StateW-1:0] StPre  = 3'd1;
  localparam logic [StateW-1:0] StByte = 3'd3;

  // Hold a stalled result steady
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o && $stable(cmd_byte_o)
      && $stable(wait_cycles_o) && $stable(link_state_o) && $stable(last_o))
    else $error("result changed while stalled");

  // Stream command bytes back to back in ascending order
  a_cmd_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_ready_i && cmd_valid_o && !last_o |=>
      out_valid_o && cmd_valid_o && cmd_index_o == $past(cmd_index_o) + 1'b1)
    else $error("command byte stream broken");

  // Show the pre-transfer state and no status bit on command results
  a_cmd_state: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && cmd_valid_o |-> link_state_o == StPre && !status_bit_o)
    else $error("command result with wrong state");

  // Drop the start strobe only during a byte transfer
  a_sync_byte: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !sync_line_n_o |-> link_state_o == StByte)
    else $error("start strobe low outside byte state");

endmodule

bind drive_serial_status_link_unit dssl_checker u_checker (.*);

`default_nettype wire

// ----- tb/drive_serial_status_link_unit_tb.sv -----
// ----------------------------------------------------------------------------
// drive_serial_status_link_unit_tb: self-checking bench for the link unit
// Runs directed status loads and a state walk, then whole serial frames with
// random command bits, stray requests and random idling on both channels.
// Every result is checked field by field against a cycle-free predictor.
// ----------------------------------------------------------------------------
`default_nettype none

module drive_serial_status_link_unit_tb;
  import dssl_pkg::*;

  localparam int CycleLimit = 200000;
  localparam logic [OpcodeW-1:0] OpUnused = 2'd3;
  localparam logic [WaitW-1:0] WaitMax = 24'hFFFFFF;

  typedef enum logic [StateW-1:0] {
    LinkReset,
    LinkPre,
    LinkBegin,
    LinkByte,
    LinkInterFirst,
    LinkInterOther,
    LinkEnd
  } link_state_e;

  typedef struct packed {
    logic               status_bit;
    logic               req_n;
    logic               sync_n;
    logic [StateW-1:0]  state;
    logic [WaitW-1:0]   hold_cycles;
    logic               cmd_valid;
    logic [CmdIdxW-1:0] cmd_idx;
    logic [ByteW-1:0]   cmd_byte;
    logic               last;
  } link_result_t;

  // DUT ports
  logic                clk_i          = 1'b0;
  logic                rst_ni         = 1'b0;
  logic                cfg_valid_i    = 1'b0;
  logic                cfg_ready_o;
  logic [CfgIdxW-1:0]  cfg_index_i    = '0;
  logic [WaitW-1:0]    cfg_data_i     = '0;
  logic                in_valid_i     = 1'b0;
  logic                in_ready_o;
  logic [OpcodeW-1:0]  opcode_i       = '0;
  logic                bit_in_i       = 1'b0;
  logic [StatIdxW-1:0] status_index_i = '0;
  logic [ByteW-1:0]    status_value_i = '0;
  logic                out_valid_o;
  logic                out_ready_i    = 1'b1;
  logic                status_bit_o;
  logic                req_line_n_o;
  logic                sync_line_n_o;
  logic [StateW-1:0]   link_state_o;
  logic [WaitW-1:0]    wait_cycles_o;
  logic                cmd_valid_o;
  logic [CmdIdxW-1:0]  cmd_index_o;
  logic [ByteW-1:0]    cmd_byte_o;
  logic                last_o;

  // Predictor state
  logic [ByteW-1:0]  status_mem  [FrameBytes];
  logic [ByteW-1:0]  command_mem [FrameBytes];
  logic [WaitW-1:0]  timing_reg  [5];
  int                status_ptr;
  int                command_ptr;
  link_state_e       phase;
  logic              req_n;
  logic              sync_n;
  link_result_t      pending_results[$];

  // Bookkeeping
  bit idle_en   = 1'b1;
  int n_items   = 0;
  int n_results = 0;
  int n_frames  = 0;
  int n_errors  = 0;
  int cycle_cnt = 0;

  drive_serial_status_link_unit DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_valid_i    (cfg_valid_i),
    .cfg_ready_o    (cfg_ready_o),
    .cfg_index_i    (cfg_index_i),
    .cfg_data_i     (cfg_data_i),
    .in_valid_i     (in_valid_i),
    .in_ready_o     (in_ready_o),
    .opcode_i       (opcode_i),
    .bit_in_i       (bit_in_i),
    .status_index_i (status_index_i),
    .status_value_i (status_value_i),
    .out_valid_o    (out_valid_o),
    .out_ready_i    (out_ready_i),
    .status_bit_o   (status_bit_o),
    .req_line_n_o   (req_line_n_o),
    .sync_line_n_o  (sync_line_n_o),
    .link_state_o   (link_state_o),
    .wait_cycles_o  (wait_cycles_o),
    .cmd_valid_o    (cmd_valid_o),
    .cmd_index_o    (cmd_index_o),
    .cmd_byte_o     (cmd_byte_o),
    .last_o         (last_o)
  );

  // Clock
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Stop a hung run
  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_cnt,
               pending_results.size());
      $display("FAILED: results differ");
      $finish;
    end
  end

  // Stall the result channel in random bursts
  always begin : ready_stalls
    @(negedge clk_i);
    if (idle_en && $urandom_range(0, 7) == 0) begin
      out_ready_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    out_ready_i <= 1'b1;
  end

  task automatic report_mismatch(input string field, input logic [WaitW-1:0] got,
                                 input logic [WaitW-1:0] want);
    $display("Mismatch on result %0d, %s: got %0h, expected %0h", n_results, field, got,
             want);
    n_errors++;
  endtask

  // Compare each accepted result with the oldest expectation
  always @(posedge clk_i) begin : check_results
    link_result_t got;
    link_result_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      got = '{status_bit_o, req_line_n_o, sync_line_n_o, link_state_o, wait_cycles_o,
              cmd_valid_o, cmd_index_o, cmd_byte_o, last_o};
      if (pending_results.size() == 0) begin
        report_mismatch("result with nothing pending", '0, '0);
      end else begin
        want = pending_results.pop_front();
        if (got.status_bit !== want.status_bit)
          report_mismatch("status_bit", WaitW'(got.status_bit), WaitW'(want.status_bit));
        if (got.req_n !== want.req_n)
          report_mismatch("req_line_n", WaitW'(got.req_n), WaitW'(want.req_n));
        if (got.sync_n !== want.sync_n)
          report_mismatch("sync_line_n", WaitW'(got.sync_n), WaitW'(want.sync_n));
        if (got.state !== want.state)
          report_mismatch("link_state", WaitW'(got.state), WaitW'(want.state));
        if (got.hold_cycles !== want.hold_cycles)
          report_mismatch("wait_cycles", got.hold_cycles, want.hold_cycles);
        if (got.cmd_valid !== want.cmd_valid)
          report_mismatch("cmd_valid", WaitW'(got.cmd_valid), WaitW'(want.cmd_valid));
        if (got.cmd_idx !== want.cmd_idx)
          report_mismatch("cmd_index", WaitW'(got.cmd_idx), WaitW'(want.cmd_idx));
        if (got.cmd_byte !== want.cmd_byte)
          report_mismatch("cmd_byte", WaitW'(got.cmd_byte), WaitW'(want.cmd_byte));
        if (got.last !== want.last)
          report_mismatch("last", WaitW'(got.last), WaitW'(want.last));
      end
      n_results++;
    end
  end

  // Advance the predictor by one accepted request and queue its results
  task automatic predict_link_step(input logic [OpcodeW-1:0] op, input logic b,
                                   input logic [StatIdxW-1:0] idx,
                                   input logic [ByteW-1:0] val);
    link_result_t r;
    logic [ByteW-1:0] sum;
    r = '0;
    r.last = 1'b1;
    case (op)
      OpTick: begin
        case (phase)
          LinkReset: begin
            req_n = 1'b1;
            sync_n = 1'b1;
            phase = LinkPre;
            r.hold_cycles = timing_reg[CfgPowerOnWait];
          end
          LinkPre: begin
            phase = LinkBegin;
            r.hold_cycles = timing_reg[CfgBeginWait];
          end
          LinkBegin: begin
            sync_n = 1'b0;
            phase = LinkByte;
            r.hold_cycles = timing_reg[CfgInterWait];
          end
          LinkByte: begin
            req_n = 1'b0;
            r.hold_cycles = timing_reg[CfgByteWait];
          end
          LinkInterFirst: begin
            req_n = 1'b1;
            phase = LinkByte;
            r.hold_cycles = timing_reg[CfgInterWait];
          end
          LinkInterOther: begin
            phase = LinkByte;
            r.hold_cycles = timing_reg[CfgInterWait];
          end
          LinkEnd: begin
            // Emit the whole received frame, one byte per result
            phase = LinkPre;
            n_frames++;
            for (int k = 0; k < FrameBytes; k++) begin
              r.req_n = req_n;
              r.sync_n = sync_n;
              r.state = phase;
              r.hold_cycles = timing_reg[CfgEndWait];
              r.cmd_valid = 1'b1;
              r.cmd_idx = k[CmdIdxW-1:0];
              r.cmd_byte = command_mem[k];
              r.last = (k == FrameBytes - 1);
              pending_results.push_back(r);
            end
            return;
          end
          default: begin
            phase = LinkPre;
            r.hold_cycles = timing_reg[CfgBeginWait];
          end
        endcase
      end
      OpBit: begin
        // Return a status bit and shift in a command bit, LSB first
        r.status_bit = status_mem[status_ptr / 8][status_ptr % 8];
        status_ptr = (status_ptr + 1 == TotalBits) ? 0 : status_ptr + 1;
        command_mem[command_ptr / 8][command_ptr % 8] = b;
        command_ptr++;
        if (command_ptr % 8 == 0) begin
          if (command_ptr == TotalBits) begin
            command_ptr = 0;
            phase = LinkEnd;
          end else if (command_ptr == 8) begin
            phase = LinkInterFirst;
          end else begin
            phase = LinkInterOther;
          end
          req_n = 1'b1;
          sync_n = 1'b1;
        end
      end
      OpLoad: begin
        // Write a status byte and refresh the checksum; drop the checksum index and beyond
        if (idx < StatBytes) begin
          status_mem[idx] = val;
          sum = '0;
          for (int i = 0; i < StatBytes; i++) sum += status_mem[i];
          status_mem[StatBytes] = ~sum;
        end
      end
      default: ;
    endcase
    r.req_n = req_n;
    r.sync_n = sync_n;
    r.state = phase;
    pending_results.push_back(r);
  endtask

  // Send one request and hold it until accepted; starts and ends at a falling edge
  task automatic issue_request(input logic [OpcodeW-1:0] op, input logic b,
                               input logic [StatIdxW-1:0] idx,
                               input logic [ByteW-1:0] val);
    if (idle_en && $urandom_range(0, 4) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 18)) @(negedge clk_i);
    end
    in_valid_i <= 1'b1;
    opcode_i <= op;
    bit_in_i <= b;
    status_index_i <= idx;
    status_value_i <= val;
    do @(posedge clk_i); while (!in_ready_o);
    predict_link_step(op, b, idx, val);
    n_items++;
    @(negedge clk_i);
  endtask

  task automatic issue_tick();
    issue_request(OpTick, 1'($urandom_range(0, 1)), StatIdxW'($urandom_range(0, 15)),
                  ByteW'($urandom_range(0, 255)));
  endtask

  task automatic issue_bit(input logic b);
    issue_request(OpBit, b, StatIdxW'($urandom_range(0, 15)),
                  ByteW'($urandom_range(0, 255)));
  endtask

  // Stray request: status load, unused opcode, or an out-of-turn bit or tick
  task automatic issue_noise();
    int pick;
    pick = $urandom_range(0, 9);
    if (pick < 5)
      issue_request(OpLoad, 1'($urandom_range(0, 1)), StatIdxW'($urandom_range(0, 15)),
                    ByteW'($urandom_range(0, 255)));
    else if (pick < 7)
      issue_request(OpUnused, 1'($urandom_range(0, 1)), StatIdxW'($urandom_range(0, 15)),
                    ByteW'($urandom_range(0, 255)));
    else if (pick < 9)
      issue_bit(1'($urandom_range(0, 1)));
    else
      issue_tick();
  endtask

  // Drop valid and wait until every expected result has come back
  task automatic drain_link();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk_i);
    repeat (4) @(negedge clk_i);
  endtask

  // Write one timing register; the caller drops valid afterwards
  task automatic write_reg(input logic [CfgIdxW-1:0] idx, input logic [WaitW-1:0] data);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i <= data;
    do @(posedge clk_i); while (!cfg_ready_o);
    timing_reg[idx] = data;
    @(negedge clk_i);
  endtask

  function automatic logic [WaitW-1:0] pick_wait(input int mode);
    if (mode == 0) return 24'd1;
    if (mode == 1) return WaitMax;
    return $urandom_range(0, 1) ? WaitW'($urandom_range(1, 4095))
                                : WaitW'($urandom_range(1, WaitMax));
  endfunction

  // Program all timing registers while idle: 0 minimum, 1 maximum, else random
  task automatic program_timing(input int mode);
    drain_link();
    write_reg(CfgPowerOnWait, pick_wait(mode));
    write_reg(CfgBeginWait, pick_wait(mode));
    write_reg(CfgInterWait, pick_wait(mode));
    write_reg(CfgByteWait, pick_wait(mode));
    write_reg(CfgEndWait, pick_wait(mode));
    cfg_valid_i <= 1'b0;
  endtask

  // Drive the link through to the end tick of a frame, with stray requests mixed in
  task automatic run_frame(input int noise_pct);
    bit done;
    done = 1'b0;
    while (!done) begin
      if ($urandom_range(0, 99) < noise_pct) begin
        issue_noise();
      end else if (phase == LinkEnd) begin
        issue_tick();
        done = 1'b1;
      end else if (phase != LinkByte) begin
        issue_tick();
      end else begin
        issue_tick();
        while (phase == LinkByte) issue_bit(1'($urandom_range(0, 1)));
      end
    end
  endtask

  // Status loads including the maximum value, ignored indexes and the unused opcode
  task automatic test_status_loads();
    issue_request(OpLoad, 1'b0, 4'd0, 8'hFF);
    issue_request(OpLoad, 1'b1, 4'd10, 8'hA5);
    issue_request(OpLoad, 1'b0, 4'd11, 8'h55);
    issue_request(OpLoad, 1'b1, 4'd15, 8'hFF);
    issue_request(OpUnused, 1'b1, 4'd15, 8'hFF);
  endtask

  // Walk the states from reset with the reset timing values
  task automatic test_link_walk();
    logic [ByteW-1:0] pattern;
    pattern = 8'b1010_0110;
    repeat (4) issue_tick();
    for (int i = 0; i < 8; i++) issue_bit(pattern[i]);
    issue_tick();
    for (int i = 0; i < 8; i++) issue_bit(~pattern[i]);
    issue_tick();
  endtask

  // Whole frames with every timing register at its minimum, then its maximum
  task automatic test_timing_extremes();
    program_timing(0);
    run_frame(10);
    program_timing(1);
    run_frame(10);
  endtask

  // One frame at full rate with random timing and no idling
  task automatic test_unthrottled();
    program_timing(2);
    idle_en = 1'b0;
    run_frame(10);
  endtask

  initial begin
    foreach (status_mem[i]) status_mem[i] = '0;
    foreach (command_mem[i]) command_mem[i] = '0;
    timing_reg[CfgPowerOnWait] = PowerOnWaitRst;
    timing_reg[CfgBeginWait] = BeginWaitRst;
    timing_reg[CfgInterWait] = InterWaitRst;
    timing_reg[CfgByteWait] = ByteWaitRst;
    timing_reg[CfgEndWait] = EndWaitRst;
    status_ptr = 0;
    command_ptr = 0;
    phase = LinkReset;
    req_n = 1'b1;
    sync_n = 1'b1;

    repeat (8) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    test_status_loads();
    test_link_walk();
    test_timing_extremes();
    test_unthrottled();

    drain_link();
    repeat (20) @(negedge clk_i);
    $display("Sent %0d requests and checked %0d results, including %0d full frames.",
             n_items, n_results, n_frames);
    $display("Timing registers went through reset, minimum, maximum and random values.");
    if (n_errors == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

`default_nettype wire
